@@ rtl/core/rrla_pkg.sv @@
// Types, command codes and helper functions shared by the reduced-radix limb ALU.
package rrla_pkg;

   localparam int LIMB_BITS  = 57;
   localparam int LIMB_COUNT = 9;
   localparam int WORD_W     = 64;
   localparam int CMD_W      = 3;
   localparam int IDX_W      = 4;
   localparam int LEN_W      = 10;
   localparam int BLEN_W     = 7;
   localparam int OFS_W      = 6;

   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MULW = 3'd2;
   localparam logic [CMD_W-1:0] CMD_EQ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BLEN = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BTST = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] limb_a;
      logic [WORD_W-1:0] limb_b;
   } req_type;

   typedef struct packed {
      logic [LIMB_BITS-1:0] result_limb;
      logic                 carry_flag;
      logic                 equal_flag;
      logic [LEN_W-1:0]     bit_length;
      logic                 bit_value;
      logic                 last_limb;
   } rsp_type;

   // input register contents
   typedef struct packed {
      req_type          beat;
      logic [IDX_W-1:0] idx;
      logic             last;
   } lane_type;

   // after operand preprocessing and partial products
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic              first;
      logic              last;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] pp_ll;
      logic [WORD_W-1:0] pp_lh;
      logic [WORD_W-1:0] pp_hl;
      logic [WORD_W-1:0] pp_hh;
      logic              neq;
      logic              nz;
      logic [LEN_W-1:0]  len_cand;
      logic              hit;
      logic              bit_sel;
   } pre_type;

   // full product assembled, ready for the carry stage
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic              first;
      logic              last;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] prod_lo;
      logic [WORD_W-1:0] prod_hi;
      logic              neq;
      logic              nz;
      logic [LEN_W-1:0]  len_cand;
      logic              hit;
      logic              bit_sel;
   } prod_type;

   function automatic logic [BLEN_W-1:0] bit_len64(input logic [WORD_W-1:0] v);
      logic [BLEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (v[i]) begin
            n = BLEN_W'(i + 1);
         end
      end
      return n;
   endfunction

   // bit position of the lowest bit of a limb
   function automatic logic [LEN_W-1:0] limb_base(input logic [IDX_W-1:0] idx);
      return LEN_W'(LIMB_BITS * int'(idx));
   endfunction

endpackage

@@ rtl/core/rrla_pre.sv @@
// Operand preprocessing: limb sum/difference, 32x32 partial products, compare,
// bit length candidate and bit test lookup.
module rrla_pre import rrla_pkg::*; (
   input  lane_type lane_in,
   output pre_type  pre_out
);

   logic [LEN_W-1:0]  base;
   logic [WORD_W-1:0] rel;
   logic [WORD_W-1:0] a;
   logic [WORD_W-1:0] b;

   always_comb begin
      a    = lane_in.beat.limb_a;
      b    = lane_in.beat.limb_b;
      base = limb_base(lane_in.idx);
      // wraps to a huge value when the index lies below this limb
      rel  = b - {{(WORD_W-LEN_W){1'b0}}, base};

      pre_out.cmd      = lane_in.beat.cmd;
      pre_out.first    = (lane_in.idx == '0);
      pre_out.last     = lane_in.last;
      pre_out.sum      = (lane_in.beat.cmd == CMD_SUB) ? (a - b) : (a + b);
      pre_out.pp_ll    = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
      pre_out.pp_lh    = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
      pre_out.pp_hl    = {32'd0, a[63:32]} * {32'd0, b[31:0]};
      pre_out.pp_hh    = {32'd0, a[63:32]} * {32'd0, b[63:32]};
      pre_out.neq      = (a != b);
      pre_out.nz       = (a != '0);
      pre_out.len_cand = base + {{(LEN_W-BLEN_W){1'b0}}, bit_len64(a)};
      pre_out.hit      = (rel < WORD_W'(LIMB_BITS));
      pre_out.bit_sel  = a[rel[OFS_W-1:0]];
   end

endmodule

@@ rtl/core/rrla_acc.sv @@
// Carry and accumulator stage with the result register.
module rrla_acc import rrla_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     item_valid,
   input  prod_type item,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   logic [WORD_W-1:0] carry_ff, carry_in;
   logic              diff_ff, diff_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              seen_ff, seen_in;
   logic              valid_ff, valid_in;
   rsp_type           out_ff, out_in;

   logic [WORD_W-1:0]   carry_base;
   logic                diff_base;
   logic [LEN_W-1:0]    len_base;
   logic                seen_base;
   logic [WORD_W-1:0]   t;
   logic [WORD_W:0]     lo_ext;
   logic [WORD_W-1:0]   hi;
   logic [2*WORD_W-1:0] wide;

   always_comb begin
      // limb 0 starts a new operand
      carry_base = item.first ? '0 : carry_ff;
      diff_base  = item.first ? 1'b0 : diff_ff;
      len_base   = item.first ? '0 : len_ff;
      seen_base  = item.first ? 1'b0 : seen_ff;

      t      = item.sum + carry_base;
      lo_ext = {1'b0, item.prod_lo} + {1'b0, carry_base};
      hi     = item.prod_hi + {{(WORD_W-1){1'b0}}, lo_ext[WORD_W]};
      wide   = {hi, lo_ext[WORD_W-1:0]};

      carry_in = carry_base;
      diff_in  = diff_base;
      len_in   = len_base;
      seen_in  = seen_base;
      out_in   = '0;
      out_in.last_limb = item.last;

      unique case (item.cmd)
         CMD_ADD, CMD_SUB: begin
            carry_in = (item.cmd == CMD_SUB) ? WORD_W'($signed(t) >>> LIMB_BITS)
                                             : (t >> LIMB_BITS);
            if (item.last) begin
               out_in.carry_flag  = t[LIMB_BITS-1];
               out_in.result_limb = {1'b0, t[LIMB_BITS-2:0]};
            end else begin
               out_in.result_limb = t[LIMB_BITS-1:0];
            end
         end
         CMD_MULW: begin
            carry_in           = wide[LIMB_BITS +: WORD_W];
            out_in.result_limb = lo_ext[LIMB_BITS-1:0];
         end
         CMD_EQ: begin
            diff_in           = diff_base | item.neq;
            out_in.equal_flag = item.last & ~diff_in;
         end
         CMD_BLEN: begin
            if (item.nz) begin
               len_in = item.len_cand;
            end
            out_in.bit_length = item.last ? len_in : '0;
         end
         CMD_BTST: begin
            if (item.hit) begin
               seen_in = item.bit_sel;
            end
            out_in.bit_value = item.last & seen_in;
         end
         default: begin
         end
      endcase

      valid_in = advance ? item_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         carry_ff <= '0;
         diff_ff  <= 1'b0;
         len_ff   <= '0;
         seen_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance && item_valid) begin
            carry_ff <= carry_in;
            diff_ff  <= diff_in;
            len_ff   <= len_in;
            seen_ff  <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ rtl/core/reduced_radix_limb_alu_core.sv @@
// Limb-serial big-integer ALU: one limb pair per beat, lowest limb first, one
// result beat per request beat. A beat passes four register stages (input,
// partial products, product assembly, result), and a new limb is taken every
// cycle when nothing stalls. The rate is set by the carry loop in the last
// stage: one 64-bit add of the running carry onto the limb sum or the 128-bit
// product per cycle. The limb position is counted from reset; every
// LimbCount-th beat closes an operand and is flagged with last_limb.
module reduced_radix_limb_alu_core import rrla_pkg::*; #(
   parameter int LimbCount = LIMB_COUNT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   lane_type         s1_ff;
   logic             v1_ff, v1_in;
   pre_type          s2_ff, s2_in;
   logic             v2_ff, v2_in;
   prod_type         s3_ff, s3_in;
   logic             v3_ff, v3_in;

   logic free1, free2, free3, free4;
   logic cnt_last;
   logic [33:0] mid;

   // a stage may load when it is empty or its beat moves on
   assign free4     = ~rsp_valid | ~rsp_stall;
   assign free3     = ~v3_ff | free4;
   assign free2     = ~v2_ff | free3;
   assign free1     = ~v1_ff | free2;
   assign req_stall = ~free1;

   assign cnt_last = (cnt_ff == IDX_W'(LimbCount - 1));

   always_comb begin
      cnt_in = cnt_ff;
      if (req_valid && free1) begin
         cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
      end
      v1_in = free1 ? req_valid : v1_ff;
      v2_in = free2 ? v1_ff : v2_ff;
      v3_in = free3 ? v2_ff : v3_ff;
   end

   rrla_pre u_pre (
      .lane_in (s1_ff),
      .pre_out (s2_in)
   );

   // 128-bit product from the four partial products
   always_comb begin
      mid = {2'b0, s2_ff.pp_ll[63:32]} + {2'b0, s2_ff.pp_lh[31:0]}
          + {2'b0, s2_ff.pp_hl[31:0]};
      s3_in.cmd      = s2_ff.cmd;
      s3_in.first    = s2_ff.first;
      s3_in.last     = s2_ff.last;
      s3_in.sum      = s2_ff.sum;
      s3_in.prod_lo  = {mid[31:0], s2_ff.pp_ll[31:0]};
      s3_in.prod_hi  = s2_ff.pp_hh + {32'd0, s2_ff.pp_lh[63:32]}
                     + {32'd0, s2_ff.pp_hl[63:32]} + {62'd0, mid[33:32]};
      s3_in.neq      = s2_ff.neq;
      s3_in.nz       = s2_ff.nz;
      s3_in.len_cand = s2_ff.len_cand;
      s3_in.hit      = s2_ff.hit;
      s3_in.bit_sel  = s2_ff.bit_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free1 && req_valid) begin
         s1_ff.beat <= req_data;
         s1_ff.idx  <= cnt_ff;
         s1_ff.last <= cnt_last;
      end
      if (free2 && v1_ff) begin
         s2_ff <= s2_in;
      end
      if (free3 && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   rrla_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .advance    (free4),
      .item_valid (v3_ff),
      .item       (s3_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/core/rrla_check.sv @@
// Port-level checker for the limb ALU and its bind to the top level.
module rrla_check import rrla_pkg::*; #(
   parameter int LimbCount = LIMB_COUNT
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic [IDX_W-1:0] ocnt_ff, ocnt_in;
   logic             ocnt_last;

   assign ocnt_last = (ocnt_ff == IDX_W'(LimbCount - 1));

   always_comb begin
      ocnt_in = ocnt_ff;
      if (rsp_valid && !rsp_stall) begin
         ocnt_in = ocnt_last ? '0 : ocnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= '0;
      end else begin
         ocnt_ff <= ocnt_in;
      end
   end

   // every LimbCount-th result beat closes an operand
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_limb == ocnt_last))
      else $error("last_limb out of step with result count");

   // summary flags only show on the closing limb
   a_flags_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_limb) |->
         (!rsp_data.carry_flag && !rsp_data.equal_flag && !rsp_data.bit_value
          && rsp_data.bit_length == '0))
      else $error("summary flag set on a non-final limb");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("stalled result payload changed");

endmodule

bind reduced_radix_limb_alu_core rrla_check #(.LimbCount(LimbCount)) u_rrla_check (.*);

@@ tb/tb_reduced_radix_limb_alu_core.sv @@
// Self-checking testbench for the limb-serial reduced-radix big-integer ALU core.
`timescale 1ns / 1ps

module tb_reduced_radix_limb_alu_core import rrla_pkg::*; ();

   localparam logic [CMD_W-1:0]  CMD_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0]  CMD_RSVD7 = 3'd7;
   localparam logic [WORD_W-1:0] ALL_ONES  = '1;
   localparam logic [WORD_W-1:0] LIMB_MASK = {{(WORD_W-LIMB_BITS){1'b0}}, {LIMB_BITS{1'b1}}};

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;

   // predictor state: position inside the operand and the per-operand accumulators
   int unsigned      limb_pos;
   logic [WORD_W-1:0] carry_in;
   logic             diff_seen;
   logic [LEN_W-1:0] length_acc;
   logic             bit_hit;

   rsp_type expected_limbs[$];

   reduced_radix_limb_alu_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic rsp_type compute_limb_result(input req_type item);
      rsp_type           r;
      logic [WORD_W-1:0] t;
      logic [127:0]      prod;
      int                msb;
      bit                last;
      r = '0;
      last = (limb_pos == LIMB_COUNT - 1);
      // limb 0 opens a new operand
      if (limb_pos == 0) begin
         carry_in   = '0;
         diff_seen  = 1'b0;
         length_acc = '0;
         bit_hit    = 1'b0;
      end
      case (item.cmd)
         CMD_ADD, CMD_SUB: begin
            if (item.cmd == CMD_ADD) begin
               t = item.limb_a + item.limb_b + carry_in;
               carry_in = t >> LIMB_BITS;
            end else begin
               t = item.limb_a - item.limb_b + carry_in;
               carry_in = $signed(t) >>> LIMB_BITS;
            end
            if (last) begin
               r.carry_flag  = t[LIMB_BITS-1];
               r.result_limb = {1'b0, t[LIMB_BITS-2:0]};
            end else begin
               r.result_limb = t[LIMB_BITS-1:0];
            end
         end
         CMD_MULW: begin
            prod = {64'd0, item.limb_a} * {64'd0, item.limb_b} + {64'd0, carry_in};
            carry_in      = prod[LIMB_BITS+WORD_W-1:LIMB_BITS];
            r.result_limb = prod[LIMB_BITS-1:0];
         end
         CMD_EQ: begin
            if (item.limb_a != item.limb_b) diff_seen = 1'b1;
            if (last) r.equal_flag = !diff_seen;
         end
         CMD_BLEN: begin
            if (item.limb_a != '0) begin
               msb = 0;
               for (int i = 0; i < WORD_W; i++) begin
                  if (item.limb_a[i]) msb = i + 1;
               end
               length_acc = LEN_W'(LIMB_BITS * limb_pos + msb);
            end
            if (last) r.bit_length = length_acc;
         end
         CMD_BTST: begin
            if (item.limb_b / LIMB_BITS == limb_pos)
               bit_hit = item.limb_a[item.limb_b % LIMB_BITS];
            if (last) r.bit_value = bit_hit;
         end
         default: ;
      endcase
      r.last_limb = last;
      limb_pos = last ? 0 : limb_pos + 1;
      return r;
   endfunction

   task automatic send_limb(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b);
      req_type item;
      item.cmd    = cmd;
      item.limb_a = a;
      item.limb_b = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_limbs.push_back(compute_limb_result(item));
   endtask

   function automatic logic [WORD_W-1:0] pick_limb_value();
      case ($urandom_range(5))
         0:       return '0;
         1:       return ALL_ONES;
         2, 3:    return {$urandom, $urandom} & LIMB_MASK;
         4:       return {$urandom, $urandom};
         default: return WORD_W'($urandom_range(15));
      endcase
   endfunction

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_limbs.size() == 0) begin
               $error("result beat with no expectation pending");
               error_count++;
            end else begin
               want = expected_limbs.pop_front();
               check_field("result_limb", WORD_W'(want.result_limb),
                           WORD_W'(rsp_data.result_limb));
               check_field("carry_flag", WORD_W'(want.carry_flag),
                           WORD_W'(rsp_data.carry_flag));
               check_field("equal_flag", WORD_W'(want.equal_flag),
                           WORD_W'(rsp_data.equal_flag));
               check_field("bit_length", WORD_W'(want.bit_length),
                           WORD_W'(rsp_data.bit_length));
               check_field("bit_value", WORD_W'(want.bit_value),
                           WORD_W'(rsp_data.bit_value));
               check_field("last_limb", WORD_W'(want.last_limb),
                           WORD_W'(rsp_data.last_limb));
            end
         end
      end
   end

   // one operand that switches command from limb to limb, ending with two bit test limbs, with extreme limb values
   task automatic test_mixed_extremes();
      send_limb(CMD_ADD, ALL_ONES, ALL_ONES);
      send_limb(CMD_SUB, '0, ALL_ONES);
      send_limb(CMD_MULW, ALL_ONES, ALL_ONES);
      send_limb(CMD_RSVD6, ALL_ONES, ALL_ONES);
      send_limb(CMD_RSVD7, ALL_ONES, '0);
      send_limb(CMD_EQ, '0, '0);
      send_limb(CMD_BLEN, ALL_ONES, '0);
      send_limb(CMD_BTST, ALL_ONES, WORD_W'(LIMB_BITS * (LIMB_COUNT - 2) + 3));
      // index far past the operand: keeps the bit caught on the previous limb
      send_limb(CMD_BTST, '0, ALL_ONES);
   endtask

   // final product carry must be dropped
   task automatic test_multiply_carry_drop();
      for (int i = 0; i < LIMB_COUNT; i++) send_limb(CMD_MULW, LIMB_MASK, ALL_ONES);
   endtask

   task automatic test_bit_length_sparse();
      for (int i = 0; i < LIMB_COUNT; i++)
         send_limb(CMD_BLEN, (i == 4) ? {1'b1, {(WORD_W-1){1'b0}}} : '0, '0);
   endtask

   task automatic test_random_traffic(input int n_ops, input int send_pct, input int recv_pct);
      logic [CMD_W-1:0]  op_cmd;
      logic [CMD_W-1:0]  limb_cmd;
      logic [WORD_W-1:0] scalar;
      logic [WORD_W-1:0] bit_idx;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      int                top;
      bit                mixed;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < n_ops; n++) begin
         mixed   = ($urandom_range(99) < 12);
         op_cmd  = CMD_W'($urandom_range(CMD_BTST));
         scalar  = pick_limb_value();
         bit_idx = ($urandom_range(99) < 85) ? WORD_W'($urandom_range(LIMB_BITS*LIMB_COUNT-1))
                                             : {$urandom, $urandom};
         top     = $urandom_range(LIMB_COUNT);
         for (int i = 0; i < LIMB_COUNT; i++) begin
            limb_cmd = mixed ? CMD_W'($urandom_range(7)) : op_cmd;
            a = pick_limb_value();
            b = pick_limb_value();
            if (!mixed) begin
               case (op_cmd)
                  CMD_MULW: b = scalar;
                  CMD_EQ:   if ($urandom_range(9) != 0) b = a;
                  CMD_BLEN: if (i > top) a = '0;
                            else if (i == top) a = {$urandom, $urandom};
                  CMD_BTST: b = bit_idx;
                  default: ;
               endcase
            end
            send_limb(limb_cmd, a, b);
         end
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      limb_pos   = 0;
      carry_in   = '0;
      diff_seen  = 1'b0;
      length_acc = '0;
      bit_hit    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_mixed_extremes();
      test_multiply_carry_drop();
      test_bit_length_sparse();
      test_random_traffic(33, 32, 70);
      test_random_traffic(33, 70, 32);
      test_random_traffic(34, 0, 0);

      req_valid <= 1'b0;
      while (expected_limbs.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
